// File: rtl/notm_pkg.sv
package notm_pkg;

    localparam int CNT_W = 16;
    localparam int IDX_W = 16;
    localparam int SUM_W = 62;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int TLEN_W  = 5;
    localparam int TBITS_W = 16;
    localparam int BLEN_W  = 17;
    localparam int NBLK_W  = 17;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_SEL_W  = 2;

    localparam logic [REG_SEL_W-1:0] REG_TEMPLATE_LEN  = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_TEMPLATE_BITS = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_BLOCK_LEN     = 2'd2;
    localparam logic [REG_SEL_W-1:0] REG_NUM_BLOCKS    = 2'd3;

    localparam logic [TLEN_W-1:0]  TLEN_RST  = 5'd9;
    localparam logic [TBITS_W-1:0] TBITS_RST = 16'd1;
    localparam logic [BLEN_W-1:0]  BLEN_RST  = 17'd1024;
    localparam logic [NBLK_W-1:0]  NBLK_RST  = 17'd8;

    // one finished block travelling down the deviation pipe
    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] match_count;
        logic             last_block;
    } t_blk_rec;

endpackage

// File: rtl/nonoverlap_template_match_counter_top.sv
// Non-overlapping template match counter.
// Input channel: one sequence bit per word on i_bit_req, handshake i_valid / o_stall.
// Output channel: one word per finished block (index, match count, running
// squared-deviation sum with FRAC_BITS fraction bits, last-block flag),
// handshake o_valid / i_stall.
// Configuration over the APB-style port: template length, template pattern,
// block length and number of blocks; write only while no block result is pending.
// Throughput: one bit per cycle while o_stall is low. The matcher updates the window, fill,
// offset and count together on each accepted bit; block results run down a four-stage
// deviation pipe (magnitude, partial products, square with rounding, saturating accumulate).
// The block record of a closing bit waits in the matcher's block register and then passes
// the four pipe stages in order before o_valid rises.
// Bits after the last block are taken and dropped.
// Reset clears all block state and the deviation sum and loads register defaults.
// When the receiver stalls, the result holds and the pipe fills; o_stall rises
// only when the matcher's block register is still occupied.
module nonoverlap_template_match_counter_top #(
    parameter int MAX_TEMPLATE_BITS = 16,
    parameter int BLOCK_LEN_BITS    = 16,
    parameter int BLOCK_NUM_BITS    = 16,
    parameter int FRAC_BITS         = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [notm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [notm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [notm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_valid,
    input  logic                            i_bit_req,
    output logic                            o_stall,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [notm_pkg::IDX_W-1:0]      o_block_index,
    output logic [notm_pkg::CNT_W-1:0]      o_match_count,
    output logic [notm_pkg::SUM_W-1:0]      o_sq_dev_sum,
    output logic                            o_last_block
);

    localparam int M_W = $clog2(MAX_TEMPLATE_BITS + 1);

    logic [M_W-1:0]                 eff_m;
    logic [notm_pkg::TBITS_W-1:0]   tmpl;
    logic [BLOCK_LEN_BITS:0]        eff_len;
    logic [BLOCK_NUM_BITS:0]        eff_nblk;
    logic                           rec_valid;
    logic                           rec_ready;
    notm_pkg::t_blk_rec             rec;

    notm_cfg #(
        .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
        .BLOCK_LEN_BITS    (BLOCK_LEN_BITS),
        .BLOCK_NUM_BITS    (BLOCK_NUM_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_m        (eff_m),
        .o_template (tmpl),
        .o_len      (eff_len),
        .o_nblk     (eff_nblk)
    );

    notm_match #(
        .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
        .BLOCK_LEN_BITS    (BLOCK_LEN_BITS),
        .BLOCK_NUM_BITS    (BLOCK_NUM_BITS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_m         (eff_m),
        .i_template  (tmpl),
        .i_len       (eff_len),
        .i_nblk      (eff_nblk),
        .i_valid     (i_valid),
        .i_bit_req   (i_bit_req),
        .o_stall     (o_stall),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_ready (rec_ready)
    );

    notm_dev #(
        .MAX_TEMPLATE_BITS (MAX_TEMPLATE_BITS),
        .BLOCK_LEN_BITS    (BLOCK_LEN_BITS),
        .FRAC_BITS         (FRAC_BITS)
    ) u_dev (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_m           (eff_m),
        .i_len         (eff_len),
        .i_rec_valid   (rec_valid),
        .i_rec         (rec),
        .o_rec_ready   (rec_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_block_index (o_block_index),
        .o_match_count (o_match_count),
        .o_sq_dev_sum  (o_sq_dev_sum),
        .o_last_block  (o_last_block)
    );

endmodule

// File: rtl/notm_cfg.sv
module notm_cfg #(
    parameter int MAX_TEMPLATE_BITS = 16,
    parameter int BLOCK_LEN_BITS    = 16,
    parameter int BLOCK_NUM_BITS    = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [notm_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [notm_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [notm_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    output logic [$clog2(MAX_TEMPLATE_BITS+1)-1:0]   o_m,
    output logic [notm_pkg::TBITS_W-1:0]             o_template,
    output logic [BLOCK_LEN_BITS:0]                  o_len,
    output logic [BLOCK_NUM_BITS:0]                  o_nblk
);

    localparam int M_W    = $clog2(MAX_TEMPLATE_BITS + 1);
    localparam int LEN_W  = BLOCK_LEN_BITS + 1;
    localparam int NB_W   = BLOCK_NUM_BITS + 1;
    localparam int CL_W   = (LEN_W > notm_pkg::BLEN_W) ? LEN_W : notm_pkg::BLEN_W;
    localparam int CN_W   = (NB_W > notm_pkg::NBLK_W) ? NB_W : notm_pkg::NBLK_W;

    logic [notm_pkg::TLEN_W-1:0]    r_tlen;
    logic [notm_pkg::TBITS_W-1:0]   r_tbits;
    logic [notm_pkg::BLEN_W-1:0]    r_blen;
    logic [notm_pkg::NBLK_W-1:0]    r_nblk;
    logic                           wr_en;
    logic [notm_pkg::REG_SEL_W-1:0] reg_sel;
    logic [CL_W-1:0]                len_ext;
    logic [CN_W-1:0]                nblk_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[notm_pkg::REG_SEL_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen  <= notm_pkg::TLEN_RST;
            r_tbits <= notm_pkg::TBITS_RST;
            r_blen  <= notm_pkg::BLEN_RST;
            r_nblk  <= notm_pkg::NBLK_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                notm_pkg::REG_TEMPLATE_LEN:  r_tlen  <= pwdata[notm_pkg::TLEN_W-1:0];
                notm_pkg::REG_TEMPLATE_BITS: r_tbits <= pwdata[notm_pkg::TBITS_W-1:0];
                notm_pkg::REG_BLOCK_LEN:     r_blen  <= pwdata[notm_pkg::BLEN_W-1:0];
                notm_pkg::REG_NUM_BLOCKS:    r_nblk  <= pwdata[notm_pkg::NBLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            notm_pkg::REG_TEMPLATE_LEN:  prdata = notm_pkg::APB_DATA_W'(r_tlen);
            notm_pkg::REG_TEMPLATE_BITS: prdata = notm_pkg::APB_DATA_W'(r_tbits);
            notm_pkg::REG_BLOCK_LEN:     prdata = notm_pkg::APB_DATA_W'(r_blen);
            notm_pkg::REG_NUM_BLOCKS:    prdata = notm_pkg::APB_DATA_W'(r_nblk);
            default:                     prdata = '0;
        endcase
    end

    // clamp registers to the supported ranges
    always_comb begin
        if (r_tlen < notm_pkg::TLEN_W'(2)) begin
            o_m = M_W'(2);
        end else if (32'(r_tlen) > 32'(MAX_TEMPLATE_BITS)) begin
            o_m = M_W'(MAX_TEMPLATE_BITS);
        end else begin
            o_m = M_W'(r_tlen);
        end

        len_ext = CL_W'(r_blen);
        if (len_ext < CL_W'(2)) begin
            o_len = LEN_W'(2);
        end else if (len_ext > (CL_W'(1) << BLOCK_LEN_BITS)) begin
            o_len = LEN_W'(1) << BLOCK_LEN_BITS;
        end else begin
            o_len = LEN_W'(len_ext);
        end

        nblk_ext = CN_W'(r_nblk);
        if (nblk_ext < CN_W'(1)) begin
            o_nblk = NB_W'(1);
        end else if (nblk_ext > (CN_W'(1) << BLOCK_NUM_BITS)) begin
            o_nblk = NB_W'(1) << BLOCK_NUM_BITS;
        end else begin
            o_nblk = NB_W'(nblk_ext);
        end
    end

    assign o_template = r_tbits;

endmodule

// File: rtl/notm_match.sv
module notm_match #(
    parameter int MAX_TEMPLATE_BITS = 16,
    parameter int BLOCK_LEN_BITS    = 16,
    parameter int BLOCK_NUM_BITS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_TEMPLATE_BITS+1)-1:0] i_m,
    input  logic [notm_pkg::TBITS_W-1:0]           i_template,
    input  logic [BLOCK_LEN_BITS:0]                i_len,
    input  logic [BLOCK_NUM_BITS:0]                i_nblk,
    input  logic                                   i_valid,
    input  logic                                   i_bit_req,
    output logic                                   o_stall,
    output logic                                   o_rec_valid,
    output notm_pkg::t_blk_rec                     o_rec,
    input  logic                                   i_rec_ready
);

    localparam int M_W   = $clog2(MAX_TEMPLATE_BITS + 1);
    localparam int LEN_W = BLOCK_LEN_BITS + 1;
    localparam int NB_W  = BLOCK_NUM_BITS + 1;

    logic [MAX_TEMPLATE_BITS-1:0] r_win, n_win;
    logic [M_W-1:0]               r_fill, n_fill;
    logic [LEN_W-1:0]             r_off, n_off;
    logic [NB_W-1:0]              r_blk, n_blk;
    logic [notm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_rec_v;
    notm_pkg::t_blk_rec           r_rec;

    logic                         accept;
    logic                         done;
    logic                         hit;
    logic                         blk_end;
    logic [MAX_TEMPLATE_BITS-1:0] mask;
    logic [MAX_TEMPLATE_BITS-1:0] tmpl;
    logic [MAX_TEMPLATE_BITS-1:0] win_sh;
    logic [M_W-1:0]               fill_inc;
    logic [notm_pkg::CNT_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]             off_inc;
    logic [NB_W-1:0]              blk_inc;

    assign o_stall = r_rec_v && !i_rec_ready;
    assign accept  = i_valid && !o_stall;
    assign done    = r_blk >= i_nblk;

    always_comb begin
        mask     = ~({MAX_TEMPLATE_BITS{1'b1}} << i_m);
        tmpl     = MAX_TEMPLATE_BITS'(i_template) & mask;
        win_sh   = ((r_win << 1) | MAX_TEMPLATE_BITS'(i_bit_req)) & mask;
        fill_inc = (r_fill < i_m) ? r_fill + M_W'(1) : i_m;
        hit      = (fill_inc == i_m) && (win_sh == tmpl);
        cnt_inc  = (hit && r_cnt != notm_pkg::CNT_MAX) ? r_cnt + notm_pkg::CNT_W'(1) : r_cnt;
        off_inc  = r_off + LEN_W'(1);
        blk_inc  = r_blk + NB_W'(1);
        blk_end  = off_inc >= i_len;

        n_win  = r_win;
        n_fill = r_fill;
        n_off  = r_off;
        n_blk  = r_blk;
        n_cnt  = r_cnt;
        if (accept && !done) begin
            n_cnt = cnt_inc;
            // a match empties the window so matches never overlap
            n_win  = hit ? '0 : win_sh;
            n_fill = hit ? '0 : fill_inc;
            n_off  = off_inc;
            if (blk_end) begin
                n_win  = '0;
                n_fill = '0;
                n_off  = '0;
                n_cnt  = '0;
                n_blk  = blk_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_fill  <= '0;
            r_off   <= '0;
            r_blk   <= '0;
            r_cnt   <= '0;
            r_rec_v <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_fill <= n_fill;
            r_off  <= n_off;
            r_blk  <= n_blk;
            r_cnt  <= n_cnt;
            if (accept && !done && blk_end) begin
                r_rec_v <= 1'b1;
            end else if (i_rec_ready) begin
                r_rec_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !done && blk_end) begin
            r_rec.block_index <= notm_pkg::IDX_W'(r_blk);
            r_rec.match_count <= cnt_inc;
            r_rec.last_block  <= blk_inc >= i_nblk;
        end
    end

    assign o_rec_valid = r_rec_v;
    assign o_rec       = r_rec;

    a_cnt_le_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(r_off))
        else $error("match count exceeds bits seen in block");

    a_blk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !done && blk_end) |=> (r_off == '0 && r_cnt == '0 && r_fill == '0))
        else $error("block state not cleared after block end");

endmodule

// File: rtl/notm_dev.sv
module notm_dev #(
    parameter int MAX_TEMPLATE_BITS = 16,
    parameter int BLOCK_LEN_BITS    = 16,
    parameter int FRAC_BITS         = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_TEMPLATE_BITS+1)-1:0] i_m,
    input  logic [BLOCK_LEN_BITS:0]                i_len,
    input  logic                                   i_rec_valid,
    input  notm_pkg::t_blk_rec                     i_rec,
    output logic                                   o_rec_ready,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [notm_pkg::IDX_W-1:0]             o_block_index,
    output logic [notm_pkg::CNT_W-1:0]             o_match_count,
    output logic [notm_pkg::SUM_W-1:0]             o_sq_dev_sum,
    output logic                                   o_last_block
);

    localparam int LEN_W  = BLOCK_LEN_BITS + 1;
    localparam int NUM_W  = LEN_W + 1;
    localparam int SH_W   = NUM_W + FRAC_BITS + 1;
    localparam int MAG_W  = ((BLOCK_LEN_BITS > notm_pkg::CNT_W) ? BLOCK_LEN_BITS
                                                                 : notm_pkg::CNT_W) + FRAC_BITS;
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int TERM_W = RND_W - FRAC_BITS;
    localparam int CMP_W  = (TERM_W > notm_pkg::SUM_W) ? TERM_W : notm_pkg::SUM_W;
    localparam int SUM_W  = notm_pkg::SUM_W;

    logic [MAG_W-1:0]        r_mean;
    logic [NUM_W-1:0]        num;
    logic [SH_W-1:0]         mean_num;

    logic                    r_va, r_vb, r_vc, r_vo;
    logic                    rdy_a, rdy_b, rdy_c, rdy_o;
    notm_pkg::t_blk_rec      r_rec_a, r_rec_b, r_rec_c, r_rec_o;
    logic [MAG_W-1:0]        r_mag;
    logic [2*LO_W-1:0]       r_pp_ll;
    logic [LO_W+HI_W-1:0]    r_pp_lh;
    logic [2*HI_W-1:0]       r_pp_hh;
    logic [SUM_W-1:0]        r_term;
    logic [SUM_W-1:0]        r_acc;

    logic [MAG_W-1:0]        cnt_fx;
    logic [MAG_W-1:0]        mag;
    logic [LO_W-1:0]         mag_lo;
    logic [HI_W-1:0]         mag_hi;
    logic [PROD_W-1:0]       sq;
    logic [RND_W-1:0]        rnd;
    logic [TERM_W-1:0]       term_full;
    logic [CMP_W-1:0]        term_ext;
    logic [SUM_W-1:0]        term_sat;
    logic [SUM_W:0]          acc_sum;

    // mean (M-m+1)/2^m in fixed point, rounded half up; the user must keep config static while running (unchecked)
    always_comb begin
        if ((NUM_W'(i_len) + NUM_W'(1)) > NUM_W'(i_m)) begin
            num = NUM_W'(i_len) + NUM_W'(1) - NUM_W'(i_m);
        end else begin
            num = '0;
        end
        mean_num = (SH_W'(num) << FRAC_BITS) + (SH_W'(1) << (i_m - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        r_mean <= MAG_W'(mean_num >> i_m);
    end

    assign rdy_o       = !r_vo || !i_stall;
    assign rdy_c       = !r_vc || rdy_o;
    assign rdy_b       = !r_vb || rdy_c;
    assign rdy_a       = !r_va || rdy_b;
    assign o_rec_ready = rdy_a;

    always_comb begin
        cnt_fx = MAG_W'(i_rec.match_count) << FRAC_BITS;
        mag    = (cnt_fx >= r_mean) ? cnt_fx - r_mean : r_mean - cnt_fx;
        mag_lo = r_mag[LO_W-1:0];
        mag_hi = r_mag[MAG_W-1:LO_W];

        sq = (PROD_W'(r_pp_hh) << (2 * LO_W))
           + (PROD_W'(r_pp_lh) << (LO_W + 1))
           + PROD_W'(r_pp_ll);
        rnd       = RND_W'(sq) + (RND_W'(1) << (FRAC_BITS - 1));
        term_full = TERM_W'(rnd >> FRAC_BITS);
        term_ext  = CMP_W'(term_full);
        term_sat  = (term_ext > CMP_W'(notm_pkg::SUM_MAX)) ? notm_pkg::SUM_MAX
                                                           : SUM_W'(term_ext);

        acc_sum = {1'b0, r_acc} + {1'b0, r_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            r_vo  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (rdy_a) begin
                r_va <= i_rec_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_o) begin
                r_vo <= r_vc;
                if (r_vc) begin
                    r_acc <= acc_sum[SUM_W] ? notm_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_rec_valid) begin
            r_rec_a <= i_rec;
            r_mag   <= mag;
        end
        // square split into half-width partial products
        if (rdy_b && r_va) begin
            r_rec_b <= r_rec_a;
            r_pp_ll <= (2*LO_W)'(mag_lo) * (2*LO_W)'(mag_lo);
            r_pp_lh <= (LO_W+HI_W)'(mag_lo) * (LO_W+HI_W)'(mag_hi);
            r_pp_hh <= (2*HI_W)'(mag_hi) * (2*HI_W)'(mag_hi);
        end
        if (rdy_c && r_vb) begin
            r_rec_c <= r_rec_b;
            r_term  <= term_sat;
        end
        if (rdy_o && r_vc) begin
            r_rec_o <= r_rec_c;
        end
    end

    assign o_valid       = r_vo;
    assign o_block_index = r_rec_o.block_index;
    assign o_match_count = r_rec_o.match_count;
    assign o_last_block  = r_rec_o.last_block;
    assign o_sq_dev_sum  = r_acc;

    a_acc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc >= $past(r_acc))
        else $error("deviation sum decreased");

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && i_stall) |=> $stable(r_acc))
        else $error("deviation sum moved while result held");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && rdy_o) |=> o_valid)
        else $error("finished term did not reach the output");

endmodule
